### rtl/swrtt_pkg.sv
`default_nettype none
package swrtt_pkg;

  localparam int OpW     = 3;
  localparam int SeqW    = 32;
  localparam int MsW     = 16;
  localparam int ToW     = 24;
  localparam int ActW    = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 24;

  localparam int InDataW  = 56;
  localparam int OutDataW = 80;

  localparam logic [MsW-1:0] InitRttRst = 16'd600;
  localparam logic [MsW-1:0] InitDevRst = 16'd30;
  localparam logic [ToW-1:0] MaxToRst   = 24'd60000;
  localparam logic [ToW-1:0] TimeoutRst = 24'd720;

  typedef enum logic [OpW-1:0] {
    OP_OPEN  = 3'd0,
    OP_SEND  = 3'd1,
    OP_END   = 3'd2,
    OP_ACK   = 3'd3,
    OP_TIMER = 3'd4
  } op_t;

  typedef enum logic [ActW-1:0] {
    ACT_NONE = 2'd0,
    ACT_TX   = 2'd1,
    ACT_RETX = 2'd2,
    ACT_DONE = 2'd3
  } act_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INIT_RTT = 2'd0,
    REG_INIT_DEV = 2'd1,
    REG_MAX_TO   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [MsW-1:0]  elapsed_ms;
    logic [SeqW-1:0] ack_value;
    logic [OpW-1:0]  operation;
  } item_t;

  typedef struct packed {
    logic            waiting;
    logic [MsW-1:0]  rtt_ms;
    logic [ToW-1:0]  timeout_ms;
    logic [SeqW-1:0] sequence_out;
    logic [ActW-1:0] action;
  } result_t;

  typedef struct packed {
    logic [MsW-1:0] init_rtt;
    logic [MsW-1:0] init_dev;
    logic [ToW-1:0] max_timeout;
  } cfg_t;

endpackage
`default_nettype wire

### rtl/swrtt_in_reg.sv
`default_nettype none
module swrtt_in_reg (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  swrtt_pkg::item_t     in_item,
  output logic                 item_valid,
  input  wire                  item_take,
  output swrtt_pkg::item_t     item
);
  import swrtt_pkg::*;

  logic  valid_r;
  item_t item_r;

  // refill in the same cycle the held item moves on
  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule
`default_nettype wire

### rtl/swrtt_state.sv
`default_nettype none
module swrtt_state (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  fire,
  input  swrtt_pkg::item_t     item,
  input  swrtt_pkg::cfg_t      cfg,
  output swrtt_pkg::result_t   result
);
  import swrtt_pkg::*;

  logic [SeqW-1:0] seq_r, seq_nxt;
  logic [MsW-1:0]  rtt_r, rtt_nxt;
  logic [MsW-1:0]  dev_r, dev_nxt;
  logic [ToW-1:0]  to_r, to_nxt;
  logic            wait_r, wait_nxt;

  logic [MsW-1:0]  diff;
  logic [MsW+1:0]  dev_sum;
  logic [MsW+1:0]  rtt_sum;
  logic [MsW-1:0]  dev_upd;
  logic [MsW-1:0]  rtt_upd;
  logic [ToW-1:0]  to_upd;
  logic [ToW-1:0]  to_open;
  logic [ToW:0]    to_dbl;
  logic [SeqW-1:0] seq_inc;
  logic            ack_ok;
  act_t            act;
  logic [SeqW-1:0] seq_out;

  assign seq_inc = seq_r + SeqW'(1);
  assign ack_ok  = item.ack_value == seq_inc;
  assign diff    = (item.elapsed_ms >= rtt_r) ? item.elapsed_ms - rtt_r
                                              : rtt_r - item.elapsed_ms;
  assign dev_sum = {1'b0, dev_r, 1'b0} + {2'b00, dev_r} + {2'b00, diff};
  assign rtt_sum = {1'b0, rtt_r, 1'b0} + {2'b00, rtt_r} + {2'b00, item.elapsed_ms};
  assign dev_upd = dev_sum[MsW+1:2];
  assign rtt_upd = rtt_sum[MsW+1:2];
  assign to_upd  = {{(ToW-MsW){1'b0}}, rtt_upd}
                 + {{(ToW-MsW-2){1'b0}}, dev_upd, 2'b00};
  assign to_open = {{(ToW-MsW){1'b0}}, cfg.init_rtt}
                 + {{(ToW-MsW-2){1'b0}}, cfg.init_dev, 2'b00};
  assign to_dbl  = {to_r, 1'b0};

  always_comb begin
    seq_nxt  = seq_r;
    rtt_nxt  = rtt_r;
    dev_nxt  = dev_r;
    to_nxt   = to_r;
    wait_nxt = wait_r;
    act      = ACT_NONE;
    seq_out  = seq_r;
    case (item.operation)
      OP_OPEN: begin
        seq_nxt  = '0;
        rtt_nxt  = cfg.init_rtt;
        dev_nxt  = cfg.init_dev;
        to_nxt   = to_open;
        wait_nxt = 1'b0;
        seq_out  = '0;
      end
      OP_SEND: begin
        act      = ACT_TX;
        wait_nxt = 1'b1;
      end
      OP_END: begin
        act = ACT_TX;
      end
      OP_ACK: begin
        if (wait_r) begin
          if (ack_ok) begin
            dev_nxt  = dev_upd;
            rtt_nxt  = rtt_upd;
            to_nxt   = to_upd;
            seq_nxt  = seq_inc;
            wait_nxt = 1'b0;
            act      = ACT_DONE;
          end else begin
            act = ACT_RETX;
          end
        end
      end
      OP_TIMER: begin
        if (wait_r) begin
          to_nxt = (to_dbl > {1'b0, cfg.max_timeout}) ? cfg.max_timeout
                                                      : to_dbl[ToW-1:0];
          act    = ACT_RETX;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.action       = act;
    result.sequence_out = seq_out;
    result.timeout_ms   = to_nxt;
    result.rtt_ms       = rtt_nxt;
    result.waiting      = wait_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= '0;
      rtt_r  <= InitRttRst;
      dev_r  <= InitDevRst;
      to_r   <= TimeoutRst;
      wait_r <= 1'b0;
    end else if (fire) begin
      seq_r  <= seq_nxt;
      rtt_r  <= rtt_nxt;
      dev_r  <= dev_nxt;
      to_r   <= to_nxt;
      wait_r <= wait_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/stop_and_wait_rtt_sender.sv
`default_nettype none
// Sender side of a stop-and-wait link with smoothed round trip estimation.
// Each input transfer is one event (open, send data, send end, ack, timer
// expiry) and yields exactly one result transfer with the action to take, the
// sequence number, the retransmit timeout, the smoothed RTT and the waiting
// flag. An event is held in an input register, evaluated against the state
// registers and written to the output register, so one event is taken every
// cycle while the output is not stalled, and its result reaches the output
// through the input register and then the output register; a stalled output
// holds one result and one event in flight. Configuration registers are
// sampled when an open event is evaluated (and the timeout limit on timer
// expiry) and should be written only while no event is in flight.
module stop_and_wait_rtt_sender (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // operation[2:0], ack_value[34:3], elapsed_ms[50:35], zero fill
  input  wire  [swrtt_pkg::InDataW-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // action[1:0], sequence_out[33:2], timeout_ms[57:34], rtt_ms[73:58],
  // waiting[74], zero fill
  output logic [swrtt_pkg::OutDataW-1:0]   out_tdata,
  input  wire                              cfg_we,
  input  wire  [swrtt_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire  [swrtt_pkg::CfgW-1:0]       cfg_wdata
);
  import swrtt_pkg::*;

  localparam int InUsedW  = $bits(item_t);
  localparam int OutUsedW = $bits(result_t);

  cfg_t    cfg_r;
  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    fire;
  result_t result;
  result_t out_r;
  logic    out_valid_r;

  assign in_item = in_tdata[InUsedW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_rtt    <= InitRttRst;
      cfg_r.init_dev    <= InitDevRst;
      cfg_r.max_timeout <= MaxToRst;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INIT_RTT: cfg_r.init_rtt    <= cfg_wdata[MsW-1:0];
        REG_INIT_DEV: cfg_r.init_dev    <= cfg_wdata[MsW-1:0];
        REG_MAX_TO:   cfg_r.max_timeout <= cfg_wdata[ToW-1:0];
        default: begin
        end
      endcase
    end
  end

  swrtt_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (fire),
    .item       (item)
  );

  // evaluate when the output register is free or being drained
  assign fire = item_valid && (!out_valid_r || out_tready);

  swrtt_state u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item),
    .cfg    (cfg_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW-OutUsedW){1'b0}}, out_r};

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_done_clears_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_r.action == ACT_DONE |-> !out_r.waiting)
    else $error("acknowledged result still waiting");

  a_retx_waits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_r.action == ACT_RETX |-> out_r.waiting)
    else $error("retransmit while not waiting");

  a_free_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output register");

endmodule
`default_nettype wire
